// ===== rtl/frustum_sphere_culling_defines.svh =====
// Assertion macros shared by the frustum sphere culling RTL
`ifndef FRUSTUM_SPHERE_CULLING_DEFINES_SVH
`define FRUSTUM_SPHERE_CULLING_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define FSC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define FSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/fsc_pkg.sv =====
// Package: constants, types and helpers of the frustum sphere culler
`timescale 1ns / 1ps
package fsc_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int PLANE_COUNT     = 6;
  localparam int PLANE_W         = 48;
  localparam int SUM_W           = ((67 - COORD_FRAC_BITS) > 50) ? (67 - COORD_FRAC_BITS) : 50;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_BUILD = 2'd1;
  localparam logic [1:0] CMD_TEST  = 2'd2;

  typedef struct packed {
    logic       capture;
    logic       mat_we;
    logic       bld_clear;
    logic       bld_prep;
    logic       zero_plane;
    logic       sq_en;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       div_store;
    logic       tst_mul;
    logic       res_load;
    logic [2:0] plane;
    logic [1:0] comp;
    logic [1:0] res_cmd;
  } fsc_ctl_t;

  typedef struct packed {
    logic degen;
  } fsc_sts_t;

  function automatic logic [1:0] plane_row(input logic [2:0] p);
    logic [1:0] r;
    case (p)
      3'd0, 3'd1: r = 2'd0;
      3'd2, 3'd3: r = 2'd1;
      default:    r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic plane_add(input logic [2:0] p);
    logic a;
    case (p)
      3'd0, 3'd3, 3'd4: a = 1'b1;
      default:          a = 1'b0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/frustum_sphere_culling.sv =====
// Top level of the frustum sphere culler
//
// One input stream carries commands; tuser selects the command: load a
// matrix element, build the six clip planes, or test a sphere. One result
// transfer follows every accepted command on the output stream.
// Load: element index and value in tdata; the result is all zeros.
// Build: planes are derived and normalised one after another, each through
// a shared square root unit and a shared divider that works on one
// component at a time; status flags a degenerate plane.
// Test: one plane per cycle through three 32x32 multipliers, then a
// sum and compare on the registered products.
// One command is worked on at a time; the next is taken once the previous
// result sits in the output register.
// Reset clears the matrix, the planes and the degenerate flags.
// A stalled result holds; the next command is taken and waits at its own result.
`timescale 1ns / 1ps
module frustum_sphere_culling (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [167:0] s_axis_tdata,  // elem_index, elem_value, center_x, center_y,
                                      // center_z, radius, zero pad
  input  logic [1:0]   s_axis_tuser,  // cmd
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [7:0]   m_axis_tdata   // visible, status, zero pad
);
  import fsc_pkg::*;

  fsc_ctl_t ctl;
  fsc_sts_t sts;
  logic     visible, status;

  fsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_cmd_i    (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  fsc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .elem_index_i (s_axis_tdata[3:0]),
    .elem_value_i (s_axis_tdata[35:4]),
    .center_x_i   (s_axis_tdata[67:36]),
    .center_y_i   (s_axis_tdata[99:68]),
    .center_z_i   (s_axis_tdata[131:100]),
    .radius_i     (s_axis_tdata[162:132]),
    .visible_o    (visible),
    .status_o     (status)
  );

  assign m_axis_tdata = {6'd0, status, visible};

endmodule

// ===== rtl/fsc_ctrl.sv =====
// Controller: sequences load, plane build and sphere test commands
`timescale 1ns / 1ps
`include "frustum_sphere_culling_defines.svh"
module fsc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       in_cmd_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  fsc_pkg::fsc_sts_t sts_i,
  output fsc_pkg::fsc_ctl_t ctl_o
);
  import fsc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_CHK, S_SQ, S_SQI, S_SQRT, S_DINIT, S_DIV, S_STORE,
    S_TEST, S_TEND, S_FIN
  } state_e;

  state_e     state_q;
  logic [1:0] cmd_q;
  logic [2:0] plane_q;
  logic [1:0] comp_q;
  logic [5:0] cnt_q;
  logic       out_valid_q;
  logic       accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    ctl_o            = '0;
    ctl_o.capture    = accept;
    ctl_o.mat_we     = accept && (in_cmd_i == CMD_LOAD);
    ctl_o.bld_clear  = accept && (in_cmd_i == CMD_BUILD);
    ctl_o.bld_prep   = (state_q == S_PREP);
    ctl_o.zero_plane = (state_q == S_CHK) && sts_i.degen;
    ctl_o.sq_en      = (state_q == S_SQ);
    ctl_o.sqrt_init  = (state_q == S_SQI);
    ctl_o.sqrt_step  = (state_q == S_SQRT);
    ctl_o.div_init   = (state_q == S_DINIT);
    ctl_o.div_step   = (state_q == S_DIV);
    ctl_o.div_store  = (state_q == S_STORE);
    ctl_o.tst_mul    = (state_q == S_TEST);
    ctl_o.res_load   = (state_q == S_FIN) && (!out_valid_q || out_ready_i);
    ctl_o.plane      = plane_q;
    ctl_o.comp       = comp_q;
    ctl_o.res_cmd    = cmd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= CMD_LOAD;
      plane_q     <= '0;
      comp_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_o.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            cmd_q   <= in_cmd_i;
            plane_q <= '0;
            case (in_cmd_i)
              CMD_BUILD: state_q <= S_PREP;
              CMD_TEST:  state_q <= S_TEST;
              default:   state_q <= S_FIN;
            endcase
          end
        end
        S_PREP: state_q <= S_CHK;
        S_CHK: begin
          comp_q <= '0;
          if (!sts_i.degen) begin
            state_q <= S_SQ;
          end else if (plane_q == 3'(PLANE_COUNT - 1)) begin
            state_q <= S_FIN;
          end else begin
            plane_q <= plane_q + 3'd1;
            state_q <= S_PREP;
          end
        end
        S_SQ: begin
          if (comp_q == 2'd2) begin
            state_q <= S_SQI;
          end else begin
            comp_q <= comp_q + 2'd1;
          end
        end
        S_SQI: begin
          cnt_q   <= 6'd31;
          comp_q  <= '0;
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          if (cnt_q == 6'd0) begin
            state_q <= S_DINIT;
          end else begin
            cnt_q <= cnt_q - 6'd1;
          end
        end
        S_DINIT: begin
          cnt_q   <= 6'd46;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (cnt_q == 6'd0) begin
            state_q <= S_STORE;
          end else begin
            cnt_q <= cnt_q - 6'd1;
          end
        end
        S_STORE: begin
          if (comp_q != 2'd3) begin
            comp_q  <= comp_q + 2'd1;
            state_q <= S_DINIT;
          end else if (plane_q == 3'(PLANE_COUNT - 1)) begin
            state_q <= S_FIN;
          end else begin
            plane_q <= plane_q + 3'd1;
            state_q <= S_PREP;
          end
        end
        S_TEST: begin
          if (plane_q == 3'(PLANE_COUNT - 1)) begin
            state_q <= S_TEND;
          end else begin
            plane_q <= plane_q + 3'd1;
          end
        end
        S_TEND: state_q <= S_FIN;
        S_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `FSC_ASSERT_IMPL(a_res_slot_free, clk_i, rst_ni, ctl_o.res_load, !out_valid_q || out_ready_i)
  `FSC_ASSERT_NEXT(a_div_then_store, clk_i, rst_ni, state_q == S_DIV && cnt_q == 6'd0, state_q == S_STORE)
  `FSC_ASSERT_IMPL(a_plane_range, clk_i, rst_ni, 1'b1, plane_q < 3'(PLANE_COUNT))

endmodule

// ===== rtl/fsc_dp.sv =====
// Datapath: matrix, planes, square root and divide units, sphere test
`timescale 1ns / 1ps
module fsc_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fsc_pkg::fsc_ctl_t  ctl_i,
  output fsc_pkg::fsc_sts_t  sts_o,
  input  logic [3:0]         elem_index_i,
  input  logic signed [31:0] elem_value_i,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic signed [31:0] center_z_i,
  input  logic [30:0]        radius_i,
  output logic               visible_o,
  output logic               status_o
);
  import fsc_pkg::*;

  logic signed [31:0]        matrix_q [16];
  logic signed [PLANE_W-1:0] plane_q  [PLANE_COUNT][4];
  logic [PLANE_COUNT-1:0]    degen_q;

  logic signed [31:0] cen_q [3];
  logic [30:0]        radius_q;

  logic [32:0] mag_q [4];
  logic [3:0]  neg_q;
  logic        pdeg_q;
  logic [61:0] acc_q;
  logic [63:0] v_q, root_q, bit_q;
  logic [30:0] rem_q;
  logic [46:0] sh_q, quo_q;
  logic        sat_q;

  logic [63:0] prod_q [3];
  logic [2:0]  psgn_q;
  logic        ev_q;
  logic [2:0]  evp_q;
  logic        vis_q;
  logic        vis_out_q, sts_out_q;

  // plane extraction
  logic [32:0] mag_d [4];
  logic [32:0] mx;
  logic [1:0]  shf;
  logic [3:0]  neg_d;

  always_comb begin
    logic signed [32:0] base, other, raw;
    logic [1:0] row;
    row = plane_row(ctl_i.plane);
    for (int c = 0; c < 4; c++) begin
      base = 33'(matrix_q[c*4+3]);
      case (row)
        2'd0:    other = 33'(matrix_q[c*4]);
        2'd1:    other = 33'(matrix_q[c*4+1]);
        default: other = 33'(matrix_q[c*4+2]);
      endcase
      raw       = plane_add(ctl_i.plane) ? base + other : base - other;
      neg_d[c]  = raw[32];
      mag_d[c]  = raw[32] ? 33'(-raw) : 33'(raw);
    end
    mx = mag_d[0];
    if (mag_d[1] > mx) mx = mag_d[1];
    if (mag_d[2] > mx) mx = mag_d[2];
    if (mx[32]) shf = 2'd3;
    else if (mx[31]) shf = 2'd2;
    else if (mx[30]) shf = 2'd1;
    else shf = 2'd0;
  end

  assign sts_o.degen = pdeg_q;

  // square root and divide
  logic [63:0] trial;
  logic [30:0] len;
  logic [32:0] dmag;
  logic [31:0] dt;
  logic        dge;
  logic [59:0] sqm;
  logic [46:0] resm;
  logic signed [PLANE_W-1:0] resv;

  assign trial = root_q + bit_q;
  assign len   = (root_q[30:0] == 31'd0) ? 31'd1 : root_q[30:0];
  assign dmag  = mag_q[ctl_i.comp];
  assign dt    = {rem_q, sh_q[46]};
  assign dge   = dt >= {1'b0, len};
  assign sqm   = mag_q[ctl_i.comp][29:0] * mag_q[ctl_i.comp][29:0];
  assign resm  = sat_q ? {47{1'b1}} : quo_q;
  assign resv  = neg_q[ctl_i.comp] ? -$signed({1'b0, resm}) : $signed({1'b0, resm});

  // sphere test
  logic [63:0] prod_d [3];
  logic [2:0]  psgn_d;
  logic signed [SUM_W-1:0] term [3];
  logic signed [SUM_W-1:0] dsum, lim;
  logic        reject;

  always_comb begin
    logic signed [PLANE_W-1:0] a;
    logic [PLANE_W-1:0] amag;
    logic [31:0] bmag;
    for (int k = 0; k < 3; k++) begin
      a         = plane_q[ctl_i.plane][k];
      amag      = a[PLANE_W-1] ? PLANE_W'(-a) : PLANE_W'(a);
      bmag      = cen_q[k][31] ? 32'(-cen_q[k]) : 32'(cen_q[k]);
      psgn_d[k] = a[PLANE_W-1] ^ cen_q[k][31];
      prod_d[k] = amag[32] ? {bmag, 32'd0} : amag[31:0] * bmag;
    end
  end

  always_comb begin
    logic [SUM_W-1:0] m;
    for (int k = 0; k < 3; k++) begin
      m       = SUM_W'(prod_q[k] >> COORD_FRAC_BITS);
      term[k] = psgn_q[k] ? -$signed(m) : $signed(m);
    end
    dsum   = term[0] + term[1] + term[2] + SUM_W'(plane_q[evp_q][3]);
    lim    = -$signed(SUM_W'(radius_q) << (32 - COORD_FRAC_BITS));
    reject = !degen_q[evp_q] && (dsum <= lim);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) matrix_q[i] <= '0;
      for (int p = 0; p < PLANE_COUNT; p++) begin
        for (int c = 0; c < 4; c++) plane_q[p][c] <= '0;
      end
      degen_q   <= '0;
      ev_q      <= 1'b0;
      vis_out_q <= 1'b0;
      sts_out_q <= 1'b0;
    end else begin
      if (ctl_i.mat_we) matrix_q[elem_index_i] <= elem_value_i;
      if (ctl_i.bld_clear) degen_q <= '0;
      if (ctl_i.zero_plane) begin
        for (int c = 0; c < 4; c++) plane_q[ctl_i.plane][c] <= '0;
        degen_q[ctl_i.plane] <= 1'b1;
      end
      if (ctl_i.div_store) plane_q[ctl_i.plane][ctl_i.comp] <= resv;
      ev_q <= ctl_i.tst_mul;
      if (ctl_i.res_load) begin
        vis_out_q <= (ctl_i.res_cmd == CMD_TEST) ? vis_q : 1'b0;
        sts_out_q <= (ctl_i.res_cmd == CMD_BUILD) ? |degen_q : 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cen_q[0] <= center_x_i;
      cen_q[1] <= center_y_i;
      cen_q[2] <= center_z_i;
      radius_q <= radius_i;
      vis_q    <= 1'b1;
    end else if (ev_q && reject) begin
      vis_q <= 1'b0;
    end
    if (ctl_i.bld_prep) begin
      for (int c = 0; c < 4; c++) mag_q[c] <= mag_d[c] >> shf;
      neg_q  <= neg_d;
      pdeg_q <= (mx == 33'd0);
      acc_q  <= '0;
    end
    if (ctl_i.sq_en) acc_q <= acc_q + 62'(sqm);
    if (ctl_i.sqrt_init) begin
      v_q    <= 64'(acc_q);
      root_q <= '0;
      bit_q  <= 64'd1 << 62;
    end else if (ctl_i.sqrt_step) begin
      if (v_q >= trial) begin
        v_q    <= v_q - trial;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (ctl_i.div_init) begin
      sat_q <= {13'd0, dmag} >= {len, 15'd0};
      rem_q <= 31'(dmag >> 15);
      sh_q  <= {dmag[14:0], 32'd0};
      quo_q <= '0;
    end else if (ctl_i.div_step) begin
      rem_q <= dge ? 31'(dt - {1'b0, len}) : dt[30:0];
      sh_q  <= sh_q << 1;
      quo_q <= {quo_q[45:0], dge};
    end
    if (ctl_i.tst_mul) begin
      for (int k = 0; k < 3; k++) prod_q[k] <= prod_d[k];
      psgn_q <= psgn_d;
      evp_q  <= ctl_i.plane;
    end
  end

  assign visible_o = vis_out_q;
  assign status_o  = sts_out_q;

endmodule
